/* sv/itgp_pkg.sv */
package itgp_pkg;

  localparam int ENABLE_DELAY_DEPTH = 4;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 104;
  localparam int RESULT_W   = 97;

  localparam int FT_CAUSE0_BIT = 16;
  localparam int FT_CAUSE1_BIT = 18;
  localparam int FT_PIN_BIT    = 19;
  localparam int PIN_TIMER_BIT = 3;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_TRAP  = 2'd3
  } cmd_t;

  localparam logic [4:0] REG_VECTOR         = 5'd0;
  localparam logic [4:0] REG_CAUSE          = 5'd1;
  localparam logic [4:0] REG_MASK           = 5'd2;
  localparam logic [4:0] REG_ENABLE         = 5'd3;
  localparam logic [4:0] REG_SAVED_PC       = 5'd4;
  localparam logic [4:0] REG_SUMMARY        = 5'd5;
  localparam logic [4:0] REG_PIN_CAUSE      = 5'd6;
  localparam logic [4:0] REG_PIN_INV        = 5'd7;
  localparam logic [4:0] REG_PIN_MASK       = 5'd8;
  localparam logic [4:0] REG_PORT_DIR       = 5'd9;
  localparam logic [4:0] REG_PORT_OUT       = 5'd10;
  localparam logic [4:0] REG_PORT_IN        = 5'd11;
  localparam logic [4:0] REG_PORT_IN_INV    = 5'd12;
  localparam logic [4:0] REG_PORT_IN_MASK   = 5'd13;
  localparam logic [4:0] REG_TIMER_CAUSE    = 5'd14;
  localparam logic [4:0] REG_TIMER_INV      = 5'd15;
  localparam logic [4:0] REG_TIMER_MASK     = 5'd16;
  localparam logic [4:0] REG_FREE_TIMER     = 5'd17;
  localparam logic [4:0] REG_PRESCALED      = 5'd18;
  localparam logic [4:0] REG_PRESCALE_SEL   = 5'd19;
  localparam logic [4:0] REG_CLEAR_COMPARE  = 5'd20;
  localparam logic [4:0] REG_OUTPUT_COMPARE = 5'd21;
  localparam logic [4:0] REG_SERIAL_INV     = 5'd23;
  localparam logic [4:0] REG_SERIAL_MASK    = 5'd24;

  function automatic logic [13:0] prescale_mask(input logic [15:0] sel);
    logic [13:0] m;
    unique case (sel)
      16'd1:   m = 14'h0003;
      16'd2:   m = 14'h000f;
      16'd3:   m = 14'h003f;
      16'd4:   m = 14'h00ff;
      16'd5:   m = 14'h03ff;
      16'd6:   m = 14'h0fff;
      16'd7:   m = 14'h3fff;
      default: m = 14'h0000;
    endcase
    return m;
  endfunction

endpackage

/* sv/irq_timer_gpio_peripheral.sv */
// Channel   Dir  tdata (low bit up)                                     tuser
// s_axis    in   reg_index[4:0], write_data[36:5], zero pad to 40       cmd[1:0]
// m_axis    out  read_data[31:0], irq_request[32], trap_vector[64:33],  -
//                port_out[80:65], port_dir[96:81], zero pad to 104
//
// One transaction in, one out, with the result registered; a new transaction each cycle while m_axis takes results.
// Register state updates on the accepting edge; the result register holds the
// response until m_axis takes it, and s_axis_tready is high while that register
// is empty or m_axis_tready drains it in the same cycle.
// The longest path is the prescaled timer compare, clear and increment of a tick.
// rst (synchronous, active high) clears all state registers and the result valid, not the result data.
module irq_timer_gpio_peripheral (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [itgp_pkg::IN_DATA_W-1:0] s_axis_tdata,  // reg_index, write_data
  input  logic [1:0]                     s_axis_tuser,  // cmd
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [itgp_pkg::OUT_DATA_W-1:0] m_axis_tdata  // read_data, irq_request,
                                                        // trap_vector, port_out, port_dir
);
  import itgp_pkg::*;

  localparam int EN_LAST = ENABLE_DELAY_DEPTH - 1;

  logic        in_fire;
  cmd_t        cmd;
  logic [4:0]  reg_index;
  logic [31:0] write_data;
  logic [15:0] wd_half;
  logic [7:0]  wd_byte;

  logic [31:0] vector_addr, vector_addr_next;
  logic [31:0] int_mask, int_mask_next;
  logic [31:0] irq_enable, irq_enable_next;
  logic [31:0] enable_delay [ENABLE_DELAY_DEPTH];
  logic [31:0] enable_delay_next [ENABLE_DELAY_DEPTH];
  logic [31:0] saved_pc, saved_pc_next;
  logic [2:0]  summary_cause, summary_cause_next;
  logic        top_cause, top_cause_next;
  logic [15:0] pin_cause, pin_cause_next;
  logic [15:0] pin_cause_invert, pin_cause_invert_next;
  logic [15:0] pin_cause_mask, pin_cause_mask_next;
  logic [15:0] port_direction, port_direction_next;
  logic [15:0] port_output, port_output_next;
  logic [15:0] port_input, port_input_next;
  logic [15:0] port_input_invert, port_input_invert_next;
  logic [15:0] port_input_mask, port_input_mask_next;
  logic [7:0]  timer_cause, timer_cause_next;
  logic [7:0]  timer_cause_invert, timer_cause_invert_next;
  logic [7:0]  timer_cause_mask, timer_cause_mask_next;
  logic [31:0] free_timer, free_timer_next;
  logic [15:0] prescaled_timer, prescaled_timer_next;
  logic [15:0] prescale_select, prescale_select_next;
  logic [15:0] clear_compare, clear_compare_next;
  logic [15:0] output_compare, output_compare_next;
  logic [7:0]  serial_cause_invert, serial_cause_invert_next;
  logic [7:0]  serial_cause_mask, serial_cause_mask_next;

  logic [15:0] pt_cleared;
  logic        pin_hit;
  logic        timer_hit;
  logic [31:0] read_value;
  logic [31:0] read_data;
  logic        irq_request;

  logic                 out_valid;
  logic [RESULT_W-1:0]  out_data;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_t'(s_axis_tuser);
  assign reg_index     = s_axis_tdata[4:0];
  assign write_data    = s_axis_tdata[36:5];
  assign wd_half       = write_data[15:0];
  assign wd_byte       = write_data[7:0];

  always_comb begin
    unique case (reg_index)
      REG_VECTOR:         read_value = vector_addr;
      REG_CAUSE:          read_value = {31'd0, top_cause};
      REG_MASK:           read_value = int_mask;
      REG_ENABLE:         read_value = irq_enable;
      REG_SAVED_PC:       read_value = saved_pc;
      REG_SUMMARY:        read_value = {29'd0, summary_cause};
      REG_PIN_CAUSE:      read_value = {16'd0, pin_cause};
      REG_PIN_INV:        read_value = {16'd0, pin_cause_invert};
      REG_PIN_MASK:       read_value = {16'd0, pin_cause_mask};
      REG_PORT_DIR:       read_value = {16'd0, port_direction};
      REG_PORT_OUT:       read_value = {16'd0, port_output};
      REG_PORT_IN:        read_value = {16'd0, port_input};
      REG_PORT_IN_INV:    read_value = {16'd0, port_input_invert};
      REG_PORT_IN_MASK:   read_value = {16'd0, port_input_mask};
      REG_TIMER_CAUSE:    read_value = {24'd0, timer_cause};
      REG_TIMER_INV:      read_value = {24'd0, timer_cause_invert};
      REG_TIMER_MASK:     read_value = {24'd0, timer_cause_mask};
      REG_FREE_TIMER:     read_value = free_timer;
      REG_PRESCALED:      read_value = {16'd0, prescaled_timer};
      REG_PRESCALE_SEL:   read_value = {16'd0, prescale_select};
      REG_CLEAR_COMPARE:  read_value = {16'd0, clear_compare};
      REG_OUTPUT_COMPARE: read_value = {16'd0, output_compare};
      REG_SERIAL_INV:     read_value = {24'd0, serial_cause_invert};
      REG_SERIAL_MASK:    read_value = {24'd0, serial_cause_mask};
      default:            read_value = 32'd0;
    endcase
  end

  always_comb begin
    vector_addr_next         = vector_addr;
    int_mask_next            = int_mask;
    irq_enable_next          = irq_enable;
    enable_delay_next        = enable_delay;
    saved_pc_next            = saved_pc;
    summary_cause_next       = summary_cause;
    top_cause_next           = top_cause;
    pin_cause_next           = pin_cause;
    pin_cause_invert_next    = pin_cause_invert;
    pin_cause_mask_next      = pin_cause_mask;
    port_direction_next      = port_direction;
    port_output_next         = port_output;
    port_input_next          = port_input;
    port_input_invert_next   = port_input_invert;
    port_input_mask_next     = port_input_mask;
    timer_cause_next         = timer_cause;
    timer_cause_invert_next  = timer_cause_invert;
    timer_cause_mask_next    = timer_cause_mask;
    free_timer_next          = free_timer;
    prescaled_timer_next     = prescaled_timer;
    prescale_select_next     = prescale_select;
    clear_compare_next       = clear_compare;
    output_compare_next      = output_compare;
    serial_cause_invert_next = serial_cause_invert;
    serial_cause_mask_next   = serial_cause_mask;
    pt_cleared               = prescaled_timer;
    pin_hit                  = 1'b0;
    timer_hit                = 1'b0;
    read_data                = 32'd0;

    unique case (cmd)
      CMD_TICK: begin
        port_input_next[PIN_TIMER_BIT] = free_timer[FT_PIN_BIT];

        irq_enable_next = enable_delay[0];
        for (int i = 0; i < EN_LAST; i++) begin
          enable_delay_next[i] = enable_delay[i + 1];
        end

        pin_cause_next =
          {15'd0, |((port_input_next ^ port_input_invert) & port_input_mask)};

        timer_cause_next[0] = free_timer[FT_CAUSE0_BIT];
        timer_cause_next[1] = free_timer[FT_CAUSE1_BIT];
        if (prescaled_timer == clear_compare) begin
          pt_cleared          = 16'd0;
          timer_cause_next[2] = !timer_cause[2];
        end
        timer_cause_next[3] = pt_cleared < output_compare;

        pin_hit   = |((pin_cause_next ^ pin_cause_invert) & pin_cause_mask);
        timer_hit = |((timer_cause_next ^ timer_cause_invert) & timer_cause_mask);
        summary_cause_next = {timer_hit, pin_hit, 1'b0};
        top_cause_next     = pin_hit || timer_hit;

        free_timer_next = free_timer + 32'd1;
        if ((free_timer_next[13:0] & prescale_mask(prescale_select)) == 14'd0) begin
          prescaled_timer_next = pt_cleared + 16'd1;
        end else begin
          prescaled_timer_next = pt_cleared;
        end
      end
      CMD_READ: begin
        read_data = read_value;
      end
      CMD_WRITE: begin
        unique case (reg_index)
          REG_VECTOR:   vector_addr_next = write_data;
          REG_MASK:     int_mask_next    = write_data;
          REG_ENABLE: begin
            if (write_data == 32'd0) begin
              irq_enable_next = 32'd0;
              for (int i = 0; i < ENABLE_DELAY_DEPTH; i++) begin
                enable_delay_next[i] = 32'd0;
              end
            end else begin
              enable_delay_next[EN_LAST] = write_data;
            end
          end
          REG_SAVED_PC:       saved_pc_next            = write_data;
          REG_PIN_CAUSE:      pin_cause_next           = wd_half;
          REG_PIN_INV:        pin_cause_invert_next    = wd_half;
          REG_PIN_MASK:       pin_cause_mask_next      = wd_half;
          REG_PORT_DIR:       port_direction_next      = wd_half;
          REG_PORT_OUT:       port_output_next         = wd_half;
          REG_PORT_IN_INV:    port_input_invert_next   = wd_half;
          REG_PORT_IN_MASK:   port_input_mask_next     = wd_half;
          REG_TIMER_INV:      timer_cause_invert_next  = wd_byte;
          REG_TIMER_MASK:     timer_cause_mask_next    = wd_byte;
          REG_PRESCALED:      prescaled_timer_next     = wd_half;
          REG_PRESCALE_SEL:   prescale_select_next     = wd_half;
          REG_CLEAR_COMPARE:  clear_compare_next       = wd_half;
          REG_OUTPUT_COMPARE: output_compare_next      = wd_half;
          REG_SERIAL_INV:     serial_cause_invert_next = wd_byte;
          REG_SERIAL_MASK:    serial_cause_mask_next   = wd_byte;
          default: ;
        endcase
      end
      CMD_TRAP: begin
        saved_pc_next   = write_data;
        irq_enable_next = 32'd0;
        for (int i = 0; i < ENABLE_DELAY_DEPTH; i++) begin
          enable_delay_next[i] = 32'd0;
        end
      end
    endcase

    irq_request = (irq_enable_next != 32'd0) &&
                  ((int_mask_next & {31'd0, top_cause_next}) != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_addr         <= 32'd0;
      int_mask            <= 32'd0;
      irq_enable          <= 32'd0;
      for (int i = 0; i < ENABLE_DELAY_DEPTH; i++) begin
        enable_delay[i] <= 32'd0;
      end
      saved_pc            <= 32'd0;
      summary_cause       <= 3'd0;
      top_cause           <= 1'b0;
      pin_cause           <= 16'd0;
      pin_cause_invert    <= 16'd0;
      pin_cause_mask      <= 16'd0;
      port_direction      <= 16'd0;
      port_output         <= 16'd0;
      port_input          <= 16'd0;
      port_input_invert   <= 16'd0;
      port_input_mask     <= 16'd0;
      timer_cause         <= 8'd0;
      timer_cause_invert  <= 8'd0;
      timer_cause_mask    <= 8'd0;
      free_timer          <= 32'd0;
      prescaled_timer     <= 16'd0;
      prescale_select     <= 16'd0;
      clear_compare       <= 16'd0;
      output_compare      <= 16'd0;
      serial_cause_invert <= 8'd0;
      serial_cause_mask   <= 8'd0;
    end else if (in_fire) begin
      vector_addr         <= vector_addr_next;
      int_mask            <= int_mask_next;
      irq_enable          <= irq_enable_next;
      enable_delay        <= enable_delay_next;
      saved_pc            <= saved_pc_next;
      summary_cause       <= summary_cause_next;
      top_cause           <= top_cause_next;
      pin_cause           <= pin_cause_next;
      pin_cause_invert    <= pin_cause_invert_next;
      pin_cause_mask      <= pin_cause_mask_next;
      port_direction      <= port_direction_next;
      port_output         <= port_output_next;
      port_input          <= port_input_next;
      port_input_invert   <= port_input_invert_next;
      port_input_mask     <= port_input_mask_next;
      timer_cause         <= timer_cause_next;
      timer_cause_invert  <= timer_cause_invert_next;
      timer_cause_mask    <= timer_cause_mask_next;
      free_timer          <= free_timer_next;
      prescaled_timer     <= prescaled_timer_next;
      prescale_select     <= prescale_select_next;
      clear_compare       <= clear_compare_next;
      output_compare      <= output_compare_next;
      serial_cause_invert <= serial_cause_invert_next;
      serial_cause_mask   <= serial_cause_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= {port_direction_next, port_output_next, vector_addr_next,
                   irq_request, read_data};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - RESULT_W)'(0), out_data};

`ifndef ASSERT_OFF
  a_trap_clears_enable: assert property (@(posedge clk) disable iff (rst)
    (in_fire && cmd == CMD_TRAP) |=> (irq_enable == 32'd0 && enable_delay[EN_LAST] == 32'd0))
    else $error("trap entry left interrupts enabled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> m_axis_tvalid)
    else $error("accepted transaction produced no result");

  a_timer_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(in_fire && cmd == CMD_TICK) |=> $stable(free_timer))
    else $error("free timer moved without a tick");

  a_top_cause_summary: assert property (@(posedge clk) disable iff (rst)
    top_cause == (summary_cause != 3'd0))
    else $error("top cause disagrees with summary cause");
`endif

endmodule

/* tb/sv/testbench.sv */
module testbench;
  import itgp_pkg::*;

  localparam logic [4:0] REG_SERIAL_CAUSE = 5'd22;
  localparam logic [4:0] REG_SERIAL_DATA  = 5'd25;
  localparam logic [4:0] REG_SERIAL_DIV   = 5'd26;
  localparam logic [4:0] REG_LAST_INDEX   = 5'd31;

  localparam int LONG_TICKS    = 60;
  localparam int PHASE_ITEMS   = 300;
  localparam int HOLD_CYCLES   = 120;
  localparam int LIMIT_CYCLES  = 2_000_000;

  typedef struct packed {
    logic [15:0] port_dir;
    logic [15:0] port_out;
    logic [31:0] vector;
    logic        irq;
    logic [31:0] read_data;
  } periph_result_t;

  class irq_periph_scoreboard;
    logic [31:0] vec, mask, enable, spc;
    logic [ENABLE_DELAY_DEPTH-1:0][31:0] delay_line;
    logic [2:0]  summary;
    logic        top;
    logic [15:0] pin_c, pin_inv, pin_msk, pdir, pout;
    logic [15:0] port_in, port_in_inv, port_in_msk;
    logic [7:0]  tmr_c, tmr_inv, tmr_msk, ser_inv, ser_msk;
    logic [31:0] free_cnt;
    logic [15:0] pre_cnt, pre_sel, clr_cmp, out_cmp;
    periph_result_t expected_q[$];
    int accepted, checked, mismatches, irq_high, traps;

    function new();
      vec = '0; mask = '0; enable = '0; spc = '0; delay_line = '0;
      summary = '0; top = 1'b0;
      pin_c = '0; pin_inv = '0; pin_msk = '0; pdir = '0; pout = '0;
      port_in = '0; port_in_inv = '0; port_in_msk = '0;
      tmr_c = '0; tmr_inv = '0; tmr_msk = '0; ser_inv = '0; ser_msk = '0;
      free_cnt = '0; pre_cnt = '0; pre_sel = '0; clr_cmp = '0; out_cmp = '0;
      accepted = 0; checked = 0; mismatches = 0; irq_high = 0; traps = 0;
    endfunction

    function void note_request(cmd_t op, logic [4:0] idx, logic [31:0] data);
      periph_result_t want;
      logic [31:0] rd;
      logic [31:0] step_mask;
      rd = '0;
      accepted++;
      case (op)
        CMD_TICK: begin
          port_in[PIN_TIMER_BIT] = free_cnt[FT_PIN_BIT];
          enable = delay_line[0];
          for (int i = 0; i + 1 < ENABLE_DELAY_DEPTH; i++)
            delay_line[i] = delay_line[i+1];
          pin_c = (|((port_in ^ port_in_inv) & port_in_msk)) ? 16'd1 : 16'd0;
          tmr_c[0] = free_cnt[FT_CAUSE0_BIT];
          tmr_c[1] = free_cnt[FT_CAUSE1_BIT];
          if (pre_cnt == clr_cmp) begin
            pre_cnt = '0;
            tmr_c[2] = ~tmr_c[2];
          end
          tmr_c[3] = (pre_cnt < out_cmp);
          summary = {|((tmr_c ^ tmr_inv) & tmr_msk), |((pin_c ^ pin_inv) & pin_msk), 1'b0};
          top = (summary != 3'd0);
          free_cnt = free_cnt + 32'd1;
          if (pre_sel >= 16'd1 && pre_sel <= 16'd7)
            step_mask = (32'd1 << (2 * pre_sel)) - 32'd1;
          else
            step_mask = '0;
          if ((free_cnt & step_mask) == 32'd0)
            pre_cnt = pre_cnt + 16'd1;
        end
        CMD_READ: begin
          case (idx)
            REG_VECTOR:         rd = vec;
            REG_CAUSE:          rd = {31'd0, top};
            REG_MASK:           rd = mask;
            REG_ENABLE:         rd = enable;
            REG_SAVED_PC:       rd = spc;
            REG_SUMMARY:        rd = {29'd0, summary};
            REG_PIN_CAUSE:      rd = {16'd0, pin_c};
            REG_PIN_INV:        rd = {16'd0, pin_inv};
            REG_PIN_MASK:       rd = {16'd0, pin_msk};
            REG_PORT_DIR:       rd = {16'd0, pdir};
            REG_PORT_OUT:       rd = {16'd0, pout};
            REG_PORT_IN:        rd = {16'd0, port_in};
            REG_PORT_IN_INV:    rd = {16'd0, port_in_inv};
            REG_PORT_IN_MASK:   rd = {16'd0, port_in_msk};
            REG_TIMER_CAUSE:    rd = {24'd0, tmr_c};
            REG_TIMER_INV:      rd = {24'd0, tmr_inv};
            REG_TIMER_MASK:     rd = {24'd0, tmr_msk};
            REG_FREE_TIMER:     rd = free_cnt;
            REG_PRESCALED:      rd = {16'd0, pre_cnt};
            REG_PRESCALE_SEL:   rd = {16'd0, pre_sel};
            REG_CLEAR_COMPARE:  rd = {16'd0, clr_cmp};
            REG_OUTPUT_COMPARE: rd = {16'd0, out_cmp};
            REG_SERIAL_INV:     rd = {24'd0, ser_inv};
            REG_SERIAL_MASK:    rd = {24'd0, ser_msk};
            default:            rd = '0;
          endcase
        end
        CMD_WRITE: begin
          case (idx)
            REG_VECTOR:         vec = data;
            REG_MASK:           mask = data;
            REG_ENABLE: begin
              if (data == 32'd0) begin
                enable = '0;
                delay_line = '0;
              end else begin
                delay_line[ENABLE_DELAY_DEPTH-1] = data;
              end
            end
            REG_SAVED_PC:       spc = data;
            REG_PIN_CAUSE:      pin_c = data[15:0];
            REG_PIN_INV:        pin_inv = data[15:0];
            REG_PIN_MASK:       pin_msk = data[15:0];
            REG_PORT_DIR:       pdir = data[15:0];
            REG_PORT_OUT:       pout = data[15:0];
            REG_PORT_IN_INV:    port_in_inv = data[15:0];
            REG_PORT_IN_MASK:   port_in_msk = data[15:0];
            REG_TIMER_INV:      tmr_inv = data[7:0];
            REG_TIMER_MASK:     tmr_msk = data[7:0];
            REG_PRESCALED:      pre_cnt = data[15:0];
            REG_PRESCALE_SEL:   pre_sel = data[15:0];
            REG_CLEAR_COMPARE:  clr_cmp = data[15:0];
            REG_OUTPUT_COMPARE: out_cmp = data[15:0];
            REG_SERIAL_INV:     ser_inv = data[7:0];
            REG_SERIAL_MASK:    ser_msk = data[7:0];
            default: ;
          endcase
        end
        default: begin
          spc = data;
          enable = '0;
          delay_line = '0;
          traps++;
        end
      endcase
      want.read_data = rd;
      want.irq       = (enable != 32'd0) && top && mask[0];
      want.vector    = vec;
      want.port_out  = pout;
      want.port_dir  = pdir;
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d, %s: expected %h, got %h", checked, name, want, got);
      end
    endfunction

    function void check_response(logic [OUT_DATA_W-1:0] tdata);
      periph_result_t got, want;
      got = tdata[RESULT_W-1:0];
      checked++;
      if (got.irq === 1'b1)
        irq_high++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing outstanding: %h", checked, tdata);
        return;
      end
      want = expected_q.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("irq_request", 32'(want.irq), 32'(got.irq));
      compare_field("trap_vector", want.vector, got.vector);
      compare_field("port_out", 32'(want.port_out), 32'(got.port_out));
      compare_field("port_dir", 32'(want.port_dir), 32'(got.port_dir));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  irq_periph_scoreboard sb;
  int items_sent;
  bit tx_idle, rx_idle, rx_steady, hold_armed, hold_done;

  irq_timer_gpio_peripheral dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] write_value(logic [4:0] idx);
    case (idx)
      REG_CLEAR_COMPARE, REG_OUTPUT_COMPARE, REG_PRESCALED:
        return $urandom_range(0, 1) ? $urandom_range(0, 48) : $urandom;
      REG_PRESCALE_SEL:
        return ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : $urandom;
      REG_ENABLE:
        return ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;
      default:
        return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_response(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(cmd_t'(s_axis_tuser), s_axis_tdata[4:0], s_axis_tdata[36:5]);
    end
  end

  task automatic send_item(cmd_t op, logic [4:0] idx, logic [31:0] data);
    int n;
    s_axis_tdata  <= {3'b000, data, idx};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    n = tx_idle ? idle_len() : 0;
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic random_request();
    int r;
    logic [4:0] idx;
    r = $urandom_range(0, 99);
    idx = 5'($urandom_range(0, 31));
    if (r < 45) begin
      send_item(CMD_TICK, idx, $urandom);
    end else if (r < 65) begin
      send_item(CMD_READ, idx, $urandom);
    end else if (r < 95) begin
      if ($urandom_range(0, 4) != 0) begin
        do idx = 5'($urandom_range(0, 24));
        while (idx == REG_CAUSE || idx == REG_SUMMARY || idx == REG_PORT_IN ||
               idx == REG_TIMER_CAUSE || idx == REG_FREE_TIMER || idx == REG_SERIAL_CAUSE);
      end
      send_item(CMD_WRITE, idx, write_value(idx));
    end else begin
      send_item(CMD_TRAP, idx, $urandom);
    end
  endtask

  // arm an interrupt source, let the enable ripple along the delay line, then take or drop it
  task automatic irq_sequence();
    send_item(CMD_WRITE, REG_MASK, $urandom_range(0, 1) ? 32'd1 : $urandom);
    send_item(CMD_WRITE, REG_TIMER_INV, $urandom);
    send_item(CMD_WRITE, REG_TIMER_MASK, $urandom);
    send_item(CMD_WRITE, REG_OUTPUT_COMPARE, $urandom_range(0, 64));
    send_item(CMD_WRITE, REG_PORT_IN_INV, $urandom);
    send_item(CMD_WRITE, REG_PORT_IN_MASK, $urandom);
    send_item(CMD_WRITE, REG_PIN_INV, $urandom);
    send_item(CMD_WRITE, REG_PIN_MASK, $urandom);
    send_item(CMD_WRITE, REG_ENABLE, $urandom | 32'd1);
    repeat ($urandom_range(3, 8)) send_item(CMD_TICK, '0, '0);
    send_item(CMD_READ, REG_CAUSE, '0);
    send_item(CMD_READ, REG_ENABLE, '0);
    send_item(CMD_READ, REG_SUMMARY, '0);
    if ($urandom_range(0, 1))
      send_item(CMD_TRAP, '0, $urandom);
    else
      send_item(CMD_WRITE, REG_ENABLE, 32'd0);
  endtask

  initial begin
    int n;
    int val;
    m_axis_tready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        val = 0;
        n = HOLD_CYCLES;
      end else if (m_axis_tready && rx_idle && !rx_steady && (idle_len() > 0)) begin
        val = 0;
        n = idle_len() + 1;
      end else begin
        val = 1;
        n = $urandom_range(1, 8);
      end
      m_axis_tready <= val[0];
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("** irq_timer_gpio_peripheral: FAILED **");
    $finish;
  end

  initial begin
    int goal;
    int p;
    sb = new();
    items_sent = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rx_steady = 1'b0;
    hold_armed = 1'b0;
    hold_done = 1'b0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_TICK;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(CMD_WRITE, REG_VECTOR, 32'hffff_ffff);
    send_item(CMD_WRITE, REG_MASK, 32'hffff_ffff);
    send_item(CMD_WRITE, REG_TIMER_MASK, 32'hffff_ffff);
    send_item(CMD_WRITE, REG_OUTPUT_COMPARE, 32'hffff_ffff);
    send_item(CMD_WRITE, REG_ENABLE, 32'd1);
    repeat (4) send_item(CMD_TICK, '0, '0);
    send_item(CMD_READ, REG_ENABLE, '0);
    send_item(CMD_WRITE, REG_ENABLE, 32'd0);
    send_item(CMD_READ, REG_ENABLE, '0);
    send_item(CMD_WRITE, REG_ENABLE, 32'hffff_ffff);
    send_item(CMD_TRAP, REG_LAST_INDEX, 32'hffff_ffff);
    send_item(CMD_READ, REG_SAVED_PC, '0);
    send_item(CMD_WRITE, REG_CAUSE, 32'hffff_ffff);
    send_item(CMD_WRITE, REG_FREE_TIMER, 32'hffff_ffff);
    send_item(CMD_READ, REG_FREE_TIMER, '0);
    send_item(CMD_WRITE, REG_SERIAL_DATA, 32'hffff_ffff);
    send_item(CMD_READ, REG_SERIAL_DIV, '0);
    send_item(CMD_WRITE, REG_LAST_INDEX, 32'hffff_ffff);
    send_item(CMD_READ, REG_LAST_INDEX, '0);
    send_item(CMD_WRITE, REG_CLEAR_COMPARE, 32'd0);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_READ, REG_TIMER_CAUSE, '0);

    // run a steady stretch of ticks with pin and timer causes armed
    wait_drained();
    rx_steady = 1'b1;
    tx_idle = 1'b0;
    send_item(CMD_WRITE, REG_MASK, 32'd1);
    send_item(CMD_WRITE, REG_ENABLE, 32'd1);
    send_item(CMD_WRITE, REG_PORT_IN_MASK, 32'h0008);
    send_item(CMD_WRITE, REG_PIN_MASK, 32'd1);
    send_item(CMD_WRITE, REG_TIMER_MASK, 32'h03);
    send_item(CMD_WRITE, REG_OUTPUT_COMPARE, 32'd0);
    send_item(CMD_WRITE, REG_PRESCALE_SEL, 32'd7);
    send_item(CMD_WRITE, REG_CLEAR_COMPARE, 32'hffff);
    repeat (LONG_TICKS) send_item(CMD_TICK, '0, '0);
    send_item(CMD_READ, REG_FREE_TIMER, '0);
    send_item(CMD_READ, REG_PORT_IN, '0);
    send_item(CMD_READ, REG_PIN_CAUSE, '0);
    send_item(CMD_READ, REG_TIMER_CAUSE, '0);
    send_item(CMD_READ, REG_SUMMARY, '0);
    send_item(CMD_READ, REG_PRESCALED, '0);
    rx_steady = 1'b0;

    for (p = 0; p < 6; p++) begin
      tx_idle = (p != 2);
      rx_idle = (p != 3);
      if (p == 2)
        hold_armed = 1'b1;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        if ($urandom_range(0, 19) == 0)
          irq_sequence();
        else
          random_request();
      end
      if (p == 1 || p == 4)
        wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("covered %0d transactions in, %0d results checked, %0d traps, %0d with irq high",
             sb.accepted, sb.checked, sb.traps, sb.irq_high);
    $display("free timer ended at %h, %0d field mismatches", sb.free_cnt, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("** irq_timer_gpio_peripheral: PASSED **");
    else
      $display("** irq_timer_gpio_peripheral: FAILED **");
    $finish;
  end

endmodule
